>>> src/rvex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared types and constants for the rv32i execute pipeline.
// ----------------------------------------------------------------------------
package rvex_pkg;

  localparam int unsigned XLEN = 32;

  localparam logic [XLEN-1:0] LINK_STEP = 32'd4;
  localparam logic [XLEN-1:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [XLEN-1:0] HALF_MASK = 32'h0000_FFFF;

  // operation codes as they arrive on cmd
  localparam logic [5:0] CMD_LUI    = 6'd0;
  localparam logic [5:0] CMD_AUIPC  = 6'd1;
  localparam logic [5:0] CMD_JAL    = 6'd2;
  localparam logic [5:0] CMD_JALR   = 6'd3;
  localparam logic [5:0] CMD_BEQ    = 6'd4;
  localparam logic [5:0] CMD_BNE    = 6'd5;
  localparam logic [5:0] CMD_BLT    = 6'd6;
  localparam logic [5:0] CMD_BGE    = 6'd7;
  localparam logic [5:0] CMD_BLTU   = 6'd8;
  localparam logic [5:0] CMD_BGEU   = 6'd9;
  localparam logic [5:0] CMD_LB     = 6'd10;
  localparam logic [5:0] CMD_LH     = 6'd11;
  localparam logic [5:0] CMD_LW     = 6'd12;
  localparam logic [5:0] CMD_LBU    = 6'd13;
  localparam logic [5:0] CMD_LHU    = 6'd14;
  localparam logic [5:0] CMD_SB     = 6'd15;
  localparam logic [5:0] CMD_SH     = 6'd16;
  localparam logic [5:0] CMD_SW     = 6'd17;
  localparam logic [5:0] CMD_ADDI   = 6'd18;
  localparam logic [5:0] CMD_SLTI   = 6'd19;
  localparam logic [5:0] CMD_SLTIU  = 6'd20;
  localparam logic [5:0] CMD_XORI   = 6'd21;
  localparam logic [5:0] CMD_ORI    = 6'd22;
  localparam logic [5:0] CMD_ANDI   = 6'd23;
  localparam logic [5:0] CMD_SLLI   = 6'd24;
  localparam logic [5:0] CMD_SRLI   = 6'd25;
  localparam logic [5:0] CMD_SRAI   = 6'd26;
  localparam logic [5:0] CMD_ADD    = 6'd27;
  localparam logic [5:0] CMD_SUB    = 6'd28;
  localparam logic [5:0] CMD_SLL    = 6'd29;
  localparam logic [5:0] CMD_SLT    = 6'd30;
  localparam logic [5:0] CMD_SLTU   = 6'd31;
  localparam logic [5:0] CMD_XOR    = 6'd32;
  localparam logic [5:0] CMD_SRL    = 6'd33;
  localparam logic [5:0] CMD_SRA    = 6'd34;
  localparam logic [5:0] CMD_OR     = 6'd35;
  localparam logic [5:0] CMD_AND    = 6'd36;
  localparam logic [5:0] CMD_FENCE  = 6'd37;
  localparam logic [5:0] CMD_FENCEI = 6'd38;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SLT,
    ALU_SLTU,
    ALU_XOR,
    ALU_OR,
    ALU_AND,
    ALU_SLL,
    ALU_SRL,
    ALU_SRA,
    ALU_PASS_B
  } alu_op_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_ALU,
    RES_LINK,
    RES_STORE,
    RES_TARGET
  } res_sel_t;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_EQ,
    BR_NE,
    BR_LT,
    BR_GE,
    BR_LTU,
    BR_GEU
  } br_cond_t;

  typedef enum logic [1:0] {
    ST_BYTE,
    ST_HALF,
    ST_WORD
  } st_size_t;

  typedef struct packed {
    alu_op_t  alu_op;
    logic     use_imm;
    res_sel_t res_sel;
    br_cond_t br_cond;
    logic     jalr;
    logic     is_mem;
    st_size_t st_size;
    logic     illegal;
  } ctrl_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic ltu;
  } flags_t;

endpackage : rvex_pkg
`default_nettype wire

>>> src/rvex_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_decode
// First stage: decodes the operation code into control fields and picks
// the second alu operand.
// ----------------------------------------------------------------------------
module rvex_decode
  import rvex_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [5:0]        cmd,
  input  logic [XLEN-1:0]   pc_value,
  input  logic [XLEN-1:0]   src1_value,
  input  logic [XLEN-1:0]   src2_value,
  input  logic [XLEN-1:0]   imm_value,
  input  logic [4:0]        dest_reg,
  output logic              valid,
  output ctrl_t             ctrl,
  output logic [5:0]        op,
  output logic [4:0]        dest,
  output logic [XLEN-1:0]   pc,
  output logic [XLEN-1:0]   opa,
  output logic [XLEN-1:0]   opb,
  output logic [XLEN-1:0]   imm,
  output logic [XLEN-1:0]   src2
);

  ctrl_t ctrl_next;

  always_comb begin
    ctrl_next         = '0;
    ctrl_next.alu_op  = ALU_ADD;
    ctrl_next.res_sel = RES_ZERO;
    ctrl_next.br_cond = BR_NONE;
    ctrl_next.st_size = ST_WORD;
    case (cmd)
      CMD_LUI: begin
        ctrl_next.alu_op  = ALU_PASS_B;
        ctrl_next.use_imm = 1'b1;
        ctrl_next.res_sel = RES_ALU;
      end
      CMD_AUIPC: ctrl_next.res_sel = RES_TARGET;
      CMD_JAL: begin
        ctrl_next.res_sel = RES_LINK;
        ctrl_next.br_cond = BR_ALWAYS;
      end
      CMD_JALR: begin
        ctrl_next.use_imm = 1'b1;
        ctrl_next.res_sel = RES_LINK;
        ctrl_next.br_cond = BR_ALWAYS;
        ctrl_next.jalr    = 1'b1;
      end
      CMD_BEQ:  ctrl_next.br_cond = BR_EQ;
      CMD_BNE:  ctrl_next.br_cond = BR_NE;
      CMD_BLT:  ctrl_next.br_cond = BR_LT;
      CMD_BGE:  ctrl_next.br_cond = BR_GE;
      CMD_BLTU: ctrl_next.br_cond = BR_LTU;
      CMD_BGEU: ctrl_next.br_cond = BR_GEU;
      CMD_LB, CMD_LH, CMD_LW, CMD_LBU, CMD_LHU: begin
        ctrl_next.use_imm = 1'b1;
        ctrl_next.is_mem  = 1'b1;
      end
      CMD_SB, CMD_SH, CMD_SW: begin
        ctrl_next.use_imm = 1'b1;
        ctrl_next.is_mem  = 1'b1;
        ctrl_next.res_sel = RES_STORE;
        ctrl_next.st_size = (cmd == CMD_SB) ? ST_BYTE :
                            (cmd == CMD_SH) ? ST_HALF : ST_WORD;
      end
      CMD_ADDI, CMD_SLTI, CMD_SLTIU, CMD_XORI, CMD_ORI, CMD_ANDI,
      CMD_SLLI, CMD_SRLI, CMD_SRAI: begin
        ctrl_next.use_imm = 1'b1;
        ctrl_next.res_sel = RES_ALU;
        case (cmd)
          CMD_SLTI:  ctrl_next.alu_op = ALU_SLT;
          CMD_SLTIU: ctrl_next.alu_op = ALU_SLTU;
          CMD_XORI:  ctrl_next.alu_op = ALU_XOR;
          CMD_ORI:   ctrl_next.alu_op = ALU_OR;
          CMD_ANDI:  ctrl_next.alu_op = ALU_AND;
          CMD_SLLI:  ctrl_next.alu_op = ALU_SLL;
          CMD_SRLI:  ctrl_next.alu_op = ALU_SRL;
          CMD_SRAI:  ctrl_next.alu_op = ALU_SRA;
          default:   ctrl_next.alu_op = ALU_ADD;
        endcase
      end
      CMD_ADD, CMD_SUB, CMD_SLL, CMD_SLT, CMD_SLTU, CMD_XOR, CMD_SRL,
      CMD_SRA, CMD_OR, CMD_AND: begin
        ctrl_next.res_sel = RES_ALU;
        case (cmd)
          CMD_SUB:  ctrl_next.alu_op = ALU_SUB;
          CMD_SLL:  ctrl_next.alu_op = ALU_SLL;
          CMD_SLT:  ctrl_next.alu_op = ALU_SLT;
          CMD_SLTU: ctrl_next.alu_op = ALU_SLTU;
          CMD_XOR:  ctrl_next.alu_op = ALU_XOR;
          CMD_SRL:  ctrl_next.alu_op = ALU_SRL;
          CMD_SRA:  ctrl_next.alu_op = ALU_SRA;
          CMD_OR:   ctrl_next.alu_op = ALU_OR;
          CMD_AND:  ctrl_next.alu_op = ALU_AND;
          default:  ctrl_next.alu_op = ALU_ADD;
        endcase
      end
      CMD_FENCE, CMD_FENCEI: ctrl_next.res_sel = RES_ZERO;
      default: ctrl_next.illegal = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctrl <= ctrl_next;
    op   <= cmd;
    dest <= dest_reg;
    pc   <= pc_value;
    opa  <= src1_value;
    opb  <= ctrl_next.use_imm ? imm_value : src2_value;
    imm  <= imm_value;
    src2 <= src2_value;
  end

endmodule : rvex_decode
`default_nettype wire

>>> src/rvex_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_alu
// Second stage: alu, compare flags, effective address, branch target,
// link address and sized store data.
// ----------------------------------------------------------------------------
module rvex_alu
  import rvex_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ctrl_t             in_ctrl,
  input  logic [5:0]        in_op,
  input  logic [4:0]        in_dest,
  input  logic [XLEN-1:0]   in_pc,
  input  logic [XLEN-1:0]   in_opa,
  input  logic [XLEN-1:0]   in_opb,
  input  logic [XLEN-1:0]   in_imm,
  input  logic [XLEN-1:0]   in_src2,
  output logic              valid,
  output ctrl_t             ctrl,
  output logic [5:0]        op,
  output logic [4:0]        dest,
  output logic [XLEN-1:0]   alu_res,
  output logic [XLEN-1:0]   sum,
  output logic [XLEN-1:0]   target,
  output logic [XLEN-1:0]   link,
  output logic [XLEN-1:0]   store_data,
  output flags_t            flags
);

  logic [XLEN-1:0] sum_next;
  logic [XLEN-1:0] alu_next;
  logic [XLEN-1:0] store_next;
  logic [4:0]      shamt;
  flags_t          flags_next;

  assign sum_next = in_opa + in_opb;
  assign shamt    = in_opb[4:0];

  always_comb begin
    flags_next.eq  = (in_opa == in_opb);
    flags_next.lt  = ($signed(in_opa) < $signed(in_opb));
    flags_next.ltu = (in_opa < in_opb);
  end

  always_comb begin
    case (in_ctrl.alu_op)
      ALU_ADD:    alu_next = sum_next;
      ALU_SUB:    alu_next = in_opa - in_opb;
      ALU_SLT:    alu_next = {{(XLEN-1){1'b0}}, flags_next.lt};
      ALU_SLTU:   alu_next = {{(XLEN-1){1'b0}}, flags_next.ltu};
      ALU_XOR:    alu_next = in_opa ^ in_opb;
      ALU_OR:     alu_next = in_opa | in_opb;
      ALU_AND:    alu_next = in_opa & in_opb;
      ALU_SLL:    alu_next = in_opa << shamt;
      ALU_SRL:    alu_next = in_opa >> shamt;
      ALU_SRA:    alu_next = $unsigned($signed(in_opa) >>> shamt);
      ALU_PASS_B: alu_next = in_opb;
      default:    alu_next = '0;
    endcase
  end

  always_comb begin
    case (in_ctrl.st_size)
      ST_BYTE: store_next = in_src2 & BYTE_MASK;
      ST_HALF: store_next = in_src2 & HALF_MASK;
      default: store_next = in_src2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctrl       <= in_ctrl;
    op         <= in_op;
    dest       <= in_dest;
    alu_res    <= alu_next;
    sum        <= sum_next;
    target     <= in_pc + in_imm;
    link       <= in_pc + LINK_STEP;
    store_data <= store_next;
    flags      <= flags_next;
  end

endmodule : rvex_alu
`default_nettype wire

>>> src/rvex_resolve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_resolve
// Third stage: branch decision, redirect target and final result select,
// registered onto the output ports.
// ----------------------------------------------------------------------------
module rvex_resolve
  import rvex_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ctrl_t             in_ctrl,
  input  logic [5:0]        in_op,
  input  logic [4:0]        in_dest,
  input  logic [XLEN-1:0]   in_alu_res,
  input  logic [XLEN-1:0]   in_sum,
  input  logic [XLEN-1:0]   in_target,
  input  logic [XLEN-1:0]   in_link,
  input  logic [XLEN-1:0]   in_store_data,
  input  flags_t            in_flags,
  output logic              valid,
  output logic [5:0]        op,
  output logic [4:0]        dest,
  output logic [XLEN-1:0]   result,
  output logic [XLEN-1:0]   address,
  output logic [XLEN-1:0]   npc,
  output logic              redir,
  output logic              bad
);

  logic            taken;
  logic [XLEN-1:0] result_next;
  logic [XLEN-1:0] npc_next;

  always_comb begin
    case (in_ctrl.br_cond)
      BR_ALWAYS: taken = 1'b1;
      BR_EQ:     taken = in_flags.eq;
      BR_NE:     taken = !in_flags.eq;
      BR_LT:     taken = in_flags.lt;
      BR_GE:     taken = !in_flags.lt;
      BR_LTU:    taken = in_flags.ltu;
      BR_GEU:    taken = !in_flags.ltu;
      default:   taken = 1'b0;
    endcase
  end

  always_comb begin
    case (in_ctrl.res_sel)
      RES_ALU:    result_next = in_alu_res;
      RES_LINK:   result_next = in_link;
      RES_STORE:  result_next = in_store_data;
      RES_TARGET: result_next = in_target;
      default:    result_next = '0;
    endcase
  end

  // jalr target drops bit 0
  always_comb begin
    if (!taken) begin
      npc_next = '0;
    end else if (in_ctrl.jalr) begin
      npc_next = {in_sum[XLEN-1:1], 1'b0};
    end else begin
      npc_next = in_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    op      <= in_op;
    dest    <= in_dest;
    result  <= result_next;
    address <= in_ctrl.is_mem ? in_sum : '0;
    npc     <= npc_next;
    redir   <= taken;
    bad     <= in_ctrl.illegal;
  end

endmodule : rvex_resolve
`default_nettype wire

>>> src/rv32i_execute_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_execute_stage
// RV32I execute stage: alu, compares, load/store address, jump and branch
// resolution for one decoded instruction word.
// ----------------------------------------------------------------------------
// A word is taken on every cycle that start is high; busy is always low, so
// one instruction goes in each clock. Its result comes out on done after the
// three register stages (decode, alu, resolve), and stays on the result ports
// for one cycle only. The receiver cannot hold results off and there is no
// internal queue.
module rv32i_execute_stage
  import rvex_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [5:0]         cmd,
  input  logic [31:0]        pc_value,
  input  logic [31:0]        src1_value,
  input  logic [31:0]        src2_value,
  input  logic signed [31:0] imm,
  input  logic [4:0]         dest_reg,
  output logic               done,
  output logic [5:0]         op_echo,
  output logic [4:0]         dest_echo,
  output logic [31:0]        result_value,
  output logic [31:0]        mem_address,
  output logic [31:0]        next_pc,
  output logic               redirect,
  output logic               illegal
);

  logic            d_valid;
  ctrl_t           d_ctrl;
  logic [5:0]      d_op;
  logic [4:0]      d_dest;
  logic [XLEN-1:0] d_pc;
  logic [XLEN-1:0] d_opa;
  logic [XLEN-1:0] d_opb;
  logic [XLEN-1:0] d_imm;
  logic [XLEN-1:0] d_src2;

  logic            x_valid;
  ctrl_t           x_ctrl;
  logic [5:0]      x_op;
  logic [4:0]      x_dest;
  logic [XLEN-1:0] x_alu_res;
  logic [XLEN-1:0] x_sum;
  logic [XLEN-1:0] x_target;
  logic [XLEN-1:0] x_link;
  logic [XLEN-1:0] x_store_data;
  flags_t          x_flags;

  // fully pipelined, never stalls
  assign busy = 1'b0;

  rvex_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .cmd        (cmd),
    .pc_value   (pc_value),
    .src1_value (src1_value),
    .src2_value (src2_value),
    .imm_value  ($unsigned(imm)),
    .dest_reg   (dest_reg),
    .valid      (d_valid),
    .ctrl       (d_ctrl),
    .op         (d_op),
    .dest       (d_dest),
    .pc         (d_pc),
    .opa        (d_opa),
    .opb        (d_opb),
    .imm        (d_imm),
    .src2       (d_src2)
  );

  rvex_alu u_alu (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d_valid),
    .in_ctrl    (d_ctrl),
    .in_op      (d_op),
    .in_dest    (d_dest),
    .in_pc      (d_pc),
    .in_opa     (d_opa),
    .in_opb     (d_opb),
    .in_imm     (d_imm),
    .in_src2    (d_src2),
    .valid      (x_valid),
    .ctrl       (x_ctrl),
    .op         (x_op),
    .dest       (x_dest),
    .alu_res    (x_alu_res),
    .sum        (x_sum),
    .target     (x_target),
    .link       (x_link),
    .store_data (x_store_data),
    .flags      (x_flags)
  );

  rvex_resolve u_resolve (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (x_valid),
    .in_ctrl       (x_ctrl),
    .in_op         (x_op),
    .in_dest       (x_dest),
    .in_alu_res    (x_alu_res),
    .in_sum        (x_sum),
    .in_target     (x_target),
    .in_link       (x_link),
    .in_store_data (x_store_data),
    .in_flags      (x_flags),
    .valid         (done),
    .op            (op_echo),
    .dest          (dest_echo),
    .result        (result_value),
    .address       (mem_address),
    .npc           (next_pc),
    .redir         (redirect),
    .bad           (illegal)
  );

endmodule : rv32i_execute_stage
`default_nettype wire
